// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; tcw_seq and text_console_writer in rtl/ import this package.
package tcw_pkg;

   // Default screen geometry.
   localparam int ROWS_DEFAULT = 25;
   localparam int COLS_DEFAULT = 80;

   // Fixed field widths.
   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int CIDX_W      = 11;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Special character codes.
   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK = 1'd1;
   localparam logic [ATTR_W-1:0]    ATTR_RESET  = 8'h07;
   localparam logic [CELL_W-1:0]    BLANK_RESET = 16'h0720;

   // Result beat handed from the sequencer to the output register.
   typedef struct packed {
      logic [CELL_W-1:0]    cell_data;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
   } tcw_rsp_type;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcw_seq.sv =====
// Command sequencer: cursor state, clear sweep, scroll copy and fill, put and read.
// Depends on tcw_pkg; drives the ports of one tcw_ram instance.
module tcw_seq #(
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]        req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::CIDX_W-1:0]       req_cell_index,
   input  logic [tcw_pkg::ATTR_W-1:0]       attr,
   input  logic [tcw_pkg::CELL_W-1:0]       blank,
   input  logic                             out_free,
   output logic                             rsp_load,
   output tcw_pkg::tcw_rsp_type             rsp_next,
   output logic [$clog2(ROWS*COLS)-1:0]     mem_rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0]       mem_rd_data,
   output logic                             mem_wr_en,
   output logic [$clog2(ROWS*COLS)-1:0]     mem_wr_addr,
   output logic [tcw_pkg::CELL_W-1:0]       mem_wr_data
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int CW    = $clog2(COLS);

   localparam logic [AW-1:0] LAST_ADDR     = AW'(CELLS - 1);
   localparam logic [AW-1:0] ROW_STRIDE    = AW'(COLS);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              pw_ff, pw_in;
   logic [AW-1:0]     pw_addr_ff, pw_addr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;

   logic [CIDX_W+AW-1:0]    idx_wide;
   logic [AW-1:0]           cur_addr;
   logic [RW-1:0]           row_inc;
   logic                    col_last;
   logic [CELL_W-1:0]       rd_value;
   logic [RW+ROW_OUT_W-1:0] row_wide;
   logic [CW+COL_OUT_W-1:0] col_wide;

   assign idx_wide  = {AW'(0), req_cell_index};
   assign cur_addr  = AW'(row_ff) * ROW_STRIDE + AW'(col_ff);
   assign row_inc   = row_ff + RW'(1);
   assign col_last  = (col_ff == CW'(COLS - 1));
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pw_in       = pw_ff;
      pw_addr_in  = pw_addr_ff;
      clr_rsp_in  = clr_rsp_ff;
      cmd_in      = cmd_ff;
      ch_in       = ch_ff;
      idx_in      = idx_ff;
      idx_ok_in   = idx_ok_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      rd_value    = '0;
      rsp_load    = 1'b0;
      mem_rd_addr = idx_wide[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_addr;
      mem_wr_data = {attr, ch_ff};

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = '0;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               state_in = clr_rsp_ff ? ST_EXEC : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               ch_in     = req_char_code;
               idx_in    = idx_wide[AW-1:0];
               idx_ok_in = (idx_wide < (CIDX_W + AW)'(CELLS));
               case (req_cmd)
                  CMD_PUT: begin
                     if (req_char_code != CHAR_NUL && row_ff == RW'(ROWS)) begin
                        state_in = ST_SCROLL;
                        cnt_in   = ROW_STRIDE;
                        pw_in    = 1'b0;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  CMD_CLEAR: begin
                     state_in   = ST_CLEAR;
                     cnt_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // Read one row below, write the word in the next cycle a row higher.
            mem_rd_addr = cnt_ff;
            pw_in       = 1'b1;
            pw_addr_in  = cnt_ff - ROW_STRIDE;
            if (pw_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pw_addr_ff;
               mem_wr_data = mem_rd_data;
            end
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_FILL;
               cnt_in   = LAST_ROW_BASE;
            end
         end
         ST_FILL: begin
            if (pw_ff) begin
               // Retire the last copy before blanking the bottom row.
               mem_wr_en   = 1'b1;
               mem_wr_addr = pw_addr_ff;
               mem_wr_data = mem_rd_data;
               pw_in       = 1'b0;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cnt_ff;
               mem_wr_data = blank;
               cnt_in      = cnt_ff + AW'(1);
               if (cnt_ff == LAST_ADDR) begin
                  row_in   = RW'(ROWS - 1);
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            // Hold the read address so the registered read data stays valid.
            mem_rd_addr = idx_ff;
            if (out_free) begin
               rsp_load   = 1'b1;
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               case (cmd_ff)
                  CMD_PUT: begin
                     if (ch_ff == CHAR_NL) begin
                        col_in = '0;
                        row_in = row_inc;
                     end else if (ch_ff != CHAR_CR && ch_ff != CHAR_NUL) begin
                        mem_wr_en = 1'b1;
                        if (col_last) begin
                           col_in = '0;
                           row_in = row_inc;
                        end else begin
                           col_in = col_ff + CW'(1);
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     row_in = '0;
                  end
                  CMD_READ: begin
                     rd_value = idx_ok_ff ? mem_rd_data : '0;
                  end
                  default: begin
                     rd_value = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      row_wide = {ROW_OUT_W'(0), row_in};
      col_wide = {COL_OUT_W'(0), col_in};
      rsp_next.cell_data  = rd_value;
      rsp_next.cursor_row = row_wide[ROW_OUT_W-1:0];
      rsp_next.cursor_col = col_wide[COL_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         pw_ff      <= 1'b0;
         clr_rsp_ff <= 1'b0;
         row_ff     <= RW'(1);
         col_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pw_ff      <= pw_in;
         clr_rsp_ff <= clr_rsp_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      pw_addr_ff <= pw_addr_in;
      cmd_ff     <= cmd_in;
      ch_ff      <= ch_in;
      idx_ff     <= idx_in;
      idx_ok_ff  <= idx_ok_in;
   end

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: configuration registers, result register,
// screen memory (tcw_ram) and command sequencer (tcw_seq). Depends on tcw_pkg.
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   cmd, char_code, cell_index
//   rsp_      out        rsp_valid/rsp_stall   cell_data, cursor_row, cursor_col
//   csr_      in         csr_valid/csr_ready   index, data (register write)
//
// A put or a read is accepted in the idle state, which issues the memory read; the
// execute state then commits the write and loads the result register once it is free.
// A put that first scrolls copies each row up and then blanks the bottom row, bound
// by the one read and one write port of the screen memory.
// A clear zeroes one cell per cycle after it is accepted, then loads the result
// register.
// After reset the same sweep runs with req_stall high; configuration writes are
// taken at all times.
// A stalled result holds in the result register and the next request can be
// accepted; that request then waits in its last cycle until the result leaves.
module text_console_writer #(
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]        req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::CIDX_W-1:0]       req_cell_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]       rsp_cell_data,
   output logic [tcw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]    rsp_cursor_col,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);

   logic [ATTR_W-1:0] attr_ff;
   logic [CELL_W-1:0] blank_ff;
   logic              rsp_valid_ff;
   tcw_rsp_type       rsp_ff;
   tcw_rsp_type       rsp_next;
   logic              rsp_load;
   logic              out_free;
   logic [AW-1:0]     mem_rd_addr;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_rd_data;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_wr_en;

   // Register writes are always taken; software writes only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= ATTR_RESET;
         blank_ff <= BLANK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ATTR: begin
               attr_ff <= csr_data[ATTR_W-1:0];
            end
            CSR_BLANK: begin
               blank_ff <= csr_data[CELL_W-1:0];
            end
            default: begin
               attr_ff <= attr_ff;
            end
         endcase
      end
   end

   // The result register frees when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_ff.cell_data;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tcw_seq #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .attr           (attr_ff),
      .blank          (blank_ff),
      .out_free       (out_free),
      .rsp_load       (rsp_load),
      .rsp_next       (rsp_next),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data)
   );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for text_console_writer: drives put, clear, read and spare beats,
// predicts every result beat with an in-file scoreboard and compares them field by field.
// Depends on tcw_pkg and the RTL in rtl/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int ROWS  = ROWS_DEFAULT;
   localparam int COLS  = COLS_DEFAULT;
   localparam int CELLS = ROWS * COLS;

   // The one command code the block leaves unused; it must change nothing.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // A scroll lengthens a put and a clear sweeps every cell, and the result may then
   // sit behind a receiver stall. No correct run goes this many cycles without moving
   // a single beat on some channel.
   localparam int WATCHDOG_LIMIT = 20000;
   // A generous margin past the last result.
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 150;

   // Scoreboard: a private copy of the screen, the cursor and both registers. Each
   // accepted command advances that copy and queues the result beat it must produce.
   class console_scoreboard;
      logic [CELL_W-1:0] cells [CELLS];
      int                cur_row;
      int                cur_col;
      logic [ATTR_W-1:0] attr_byte;
      logic [CELL_W-1:0] fill_word;
      tcw_rsp_type       due_readouts [$];
      int                errors;

      function void reset_state();
         foreach (cells[i]) cells[i] = '0;
         cur_row   = 1;
         cur_col   = 0;
         attr_byte = ATTR_RESET;
         fill_word = BLANK_RESET;
         errors    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ATTR) begin
            attr_byte = data[ATTR_W-1:0];
         end else begin
            fill_word = data;
         end
      endfunction

      function void next_row();
         cur_col = 0;
         cur_row++;
      endfunction

      function tcw_rsp_type advance_console(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                            logic [CIDX_W-1:0] cidx);
         tcw_rsp_type r;
         r.cell_data = '0;
         case (cmd)
            CMD_PUT: begin
               // A NUL ends a string: no scroll, no write, no cursor move.
               if (ch != CHAR_NUL) begin
                  // Any other character, newline and carriage return included, first
                  // resolves a pending scroll.
                  if (cur_row >= ROWS) begin
                     for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
                     for (int i = 0; i < COLS; i++) cells[(ROWS - 1) * COLS + i] = fill_word;
                     cur_row = ROWS - 1;
                  end
                  if (ch == CHAR_NL) begin
                     next_row();
                  end else if (ch != CHAR_CR) begin
                     if (cur_col >= COLS) cur_col = 0;
                     cells[cur_row * COLS + cur_col] = {attr_byte, ch};
                     cur_col++;
                     if (cur_col >= COLS) next_row();
                  end
               end
            end
            CMD_CLEAR: begin
               // The column survives a clear; only the row goes home.
               foreach (cells[i]) cells[i] = '0;
               cur_row = 0;
            end
            CMD_READ: begin
               if (cidx < CELLS) r.cell_data = cells[cidx];
            end
            default: begin
            end
         endcase
         r.cursor_row = cur_row[ROW_OUT_W-1:0];
         r.cursor_col = cur_col[COL_OUT_W-1:0];
         return r;
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [CIDX_W-1:0] cidx);
         due_readouts.push_back(advance_console(cmd, ch, cidx));
      endfunction

      function void check_readout(logic [CELL_W-1:0] data, logic [ROW_OUT_W-1:0] row,
                                  logic [COL_OUT_W-1:0] col);
         tcw_rsp_type e;
         if (due_readouts.size() == 0) begin
            $display("%0t: unexpected result beat data %h row %0d col %0d",
                     $time, data, row, col);
            errors++;
            return;
         end
         e = due_readouts.pop_front();
         if (data !== e.cell_data) begin
            $display("%0t: cell_data expected %h actual %h", $time, e.cell_data, data);
            errors++;
         end
         if (row !== e.cursor_row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, e.cursor_row, row);
            errors++;
         end
         if (col !== e.cursor_col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, e.cursor_col, col);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_cmd;
   logic [CHAR_W-1:0]     req_char_code;
   logic [CIDX_W-1:0]     req_cell_index;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CELL_W-1:0]     rsp_cell_data;
   logic [ROW_OUT_W-1:0]  rsp_cursor_row;
   logic [COL_OUT_W-1:0]  rsp_cursor_col;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   console_scoreboard sb;
   // Percentage of beats on which each side holds off; zero gives a back-to-back stretch.
   int idle_pct = 22;
   int quiet_cycles = 0;

   text_console_writer #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: a beat is taken at an edge where valid is high and our stall was low.
   // The stall for the next cycle is drawn fresh at every edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_readout(rsp_cell_data, rsp_cursor_row, rsp_cursor_col);
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Watchdog: counts edges at which no channel moved a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, no beat moved for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one command beat and returns at the edge that takes it. Valid stays high
   // into the next call unless that call decides to idle first.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic [CIDX_W-1:0] cidx);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_char_code  <= ch;
      req_cell_index <= cidx;
      do @(posedge clock); while (req_stall);
      sb.note_command(cmd, ch, cidx);
   endtask

   // Writes both registers as two back-to-back beats; the upper byte of the attribute
   // beat carries noise that the block must drop.
   task automatic write_config(input logic [ATTR_W-1:0] attr, input logic [CELL_W-1:0] fill);
      logic [CSR_DATA_W-1:0] attr_word;
      attr_word = {8'($urandom_range(255)), attr};
      csr_valid <= 1'b1;
      csr_index <= CSR_ATTR;
      csr_data  <= attr_word;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_ATTR, attr_word);
      csr_index <= CSR_BLANK;
      csr_data  <= fill;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_BLANK, fill);
      csr_valid <= 1'b0;
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.due_readouts.size() != 0) @(posedge clock);
   endtask

   // One random command. Puts dominate so the cursor walks down the screen and the
   // scroll path gets heavy use; newline_pct steers between short lines that reach the
   // bottom quickly and long lines that wrap at the right edge. Clears are kept rare,
   // since each one sends the cursor back to the top row.
   task automatic random_item(input int newline_pct);
      int                p;
      int                q;
      int                near_row;
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [CIDX_W-1:0] cidx;
      ch   = 8'($urandom_range(255));
      cidx = 11'($urandom_range(2047));
      p    = $urandom_range(999);
      if (p < 4) begin
         cmd = CMD_CLEAR;
      end else if (p < 30) begin
         cmd = CMD_SPARE;
      end else if (p < 300) begin
         cmd = CMD_READ;
         q   = $urandom_range(9);
         if (q < 5) begin
            // Aim at the cursor's row, where recent writes and scrolls show up.
            near_row = (sb.cur_row >= ROWS) ? ROWS - 1 : sb.cur_row;
            cidx     = 11'(near_row * COLS + $urandom_range(COLS - 1));
         end else if (q < 6) begin
            cidx = 11'($urandom_range(2047, CELLS));
         end
      end else begin
         cmd = CMD_PUT;
         q   = $urandom_range(99);
         if (q < newline_pct) begin
            ch = CHAR_NL;
         end else if (q < newline_pct + 4) begin
            ch = CHAR_CR;
         end else if (q < newline_pct + 7) begin
            ch = CHAR_NUL;
         end else begin
            ch = 8'($urandom_range(255, 1));
         end
      end
      send_item(cmd, ch, cidx);
   endtask

   initial begin
      int newline_pct [4];
      logic [ATTR_W-1:0] attr_set [4];
      logic [CELL_W-1:0] fill_set [4];

      sb = new;
      sb.reset_state();

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PUT;
      req_char_code  = CHAR_NUL;
      req_cell_index = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_ATTR;
      csr_data       = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The block sweeps its screen after reset with req_stall high; register writes
      // are taken meanwhile and the first command simply waits for the sweep to end.
      write_config(8'hA5, BLANK_RESET);

      // Directed part: reset contents, read range edges, character extremes and each
      // special character, the spare command, and a clear that keeps the column.
      send_item(CMD_READ, 8'h00, 11'd0);
      send_item(CMD_READ, 8'hFF, 11'(CELLS - 1));
      send_item(CMD_READ, 8'h00, 11'(CELLS));
      send_item(CMD_READ, 8'h00, 11'd2047);
      send_item(CMD_PUT, 8'h41, 11'd0);
      send_item(CMD_PUT, 8'hFF, 11'd2047);
      send_item(CMD_PUT, 8'h01, 11'd0);
      send_item(CMD_PUT, 8'h80, 11'd0);
      send_item(CMD_PUT, CHAR_NUL, 11'd0);
      send_item(CMD_PUT, CHAR_CR, 11'd0);
      send_item(CMD_READ, 8'h00, 11'(COLS));
      send_item(CMD_READ, 8'h00, 11'(COLS + 1));
      send_item(CMD_READ, 8'h00, 11'(COLS + 3));
      send_item(CMD_SPARE, 8'hFF, 11'd2047);
      send_item(CMD_SPARE, 8'h00, 11'd0);
      send_item(CMD_CLEAR, 8'h5A, 11'd1234);
      send_item(CMD_READ, 8'h00, 11'(COLS));
      send_item(CMD_PUT, 8'h7E, 11'd0);
      send_item(CMD_PUT, CHAR_NL, 11'd0);
      send_item(CMD_PUT, 8'h20, 11'd0);
      send_item(CMD_READ, 8'h00, 11'(4));
      send_item(CMD_READ, 8'h00, 11'(COLS));

      // Random phases, each under its own register setting. The third phase runs
      // with no idling on either side; the second uses long lines to force wraps.
      newline_pct = '{35, 1, 12, 30};
      attr_set    = '{8'h00, 8'hFF, 8'($urandom_range(255)), ATTR_RESET};
      fill_set    = '{16'h0000, 16'hFFFF, 16'($urandom_range(65535)), BLANK_RESET};
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         write_config(attr_set[ph], fill_set[ph]);
         idle_pct = (ph == 2) ? 0 : 22;
         for (int n = 0; n < PHASE_ITEMS; n++) random_item(newline_pct[ph]);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
